### design/frustum_box_sphere_cull_core_macros.svh
// Assertion macros used by the checker file of the frustum cull core.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef FRUSTUM_BOX_SPHERE_CULL_CORE_MACROS_SVH
`define FRUSTUM_BOX_SPHERE_CULL_CORE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent matches.
`define FBSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frustum cull check failed");

// The consequent must hold in the same cycle as the antecedent.
`define FBSC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frustum cull check failed");

`endif

### design/fbsc_pkg.sv
// Shared types and constants of the frustum cull core.
// Used by the plane register file, the plane lane and the top level.
`default_nettype none

package fbsc_pkg;

	// Plane register file geometry.
	localparam int NUM_PLANES  = 6;
	localparam int PLANE_IDX_W = 3;
	localparam int CFG_DATA_W  = 64;

	// Default coordinate width (Q8.8).
	localparam int COORD_WIDTH_DEF = 16;

	// Fraction bits of a Q1.14 normal; the offset and radius are scaled by this.
	localparam int NORM_FRAC = 14;

	// Width of one packed plane coefficient.
	localparam int COEF_W = 16;

	typedef enum logic {
		OP_BOX    = 1'b0,
		OP_SPHERE = 1'b1
	} fbsc_op_t;

	typedef enum logic [1:0] {
		VERDICT_OUTSIDE   = 2'd0,
		VERDICT_INTERSECT = 2'd1,
		VERDICT_INSIDE    = 2'd2
	} fbsc_verdict_t;

	// Load enables of the lane pipeline stages.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} fbsc_stage_en_t;

	// Per-plane results of the final compare stage.
	typedef struct packed {
		logic any_front;
		logic all_front;
		logic below_neg_r;
		logic below_r;
	} fbsc_flags_t;

endpackage

`default_nettype wire

### design/fbsc_plane_regs.sv
// Configuration register file holding the six packed frustum planes.
// Depends on fbsc_pkg for the plane count and index width.
`default_nettype none

module fbsc_plane_regs (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             cfg_we,
	input  wire logic [fbsc_pkg::PLANE_IDX_W-1:0]                 cfg_index,
	input  wire logic [fbsc_pkg::CFG_DATA_W-1:0]                  cfg_data,
	output logic [fbsc_pkg::NUM_PLANES-1:0][fbsc_pkg::CFG_DATA_W-1:0] planes
);
	import fbsc_pkg::*;

	logic [NUM_PLANES-1:0][CFG_DATA_W-1:0] planes_q;

	// Writes to an index past the last plane are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= '0;
		end else if (cfg_we && (cfg_index < PLANE_IDX_W'(NUM_PLANES))) begin
			planes_q[cfg_index] <= cfg_data;
		end
	end

	assign planes = planes_q;

endmodule

`default_nettype wire

### design/fbsc_plane_lane.sv
// One plane's datapath: products, per-axis extreme selection with sum, compare.
// Depends on fbsc_pkg for the stage enable and flag structs.
`default_nettype none

module fbsc_plane_lane #(
	parameter int COORD_WIDTH = fbsc_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire fbsc_pkg::fbsc_stage_en_t        en,
	input  wire logic [fbsc_pkg::CFG_DATA_W-1:0] plane,
	input  wire logic signed [COORD_WIDTH-1:0]   lo_x_s1,
	input  wire logic signed [COORD_WIDTH-1:0]   lo_y_s1,
	input  wire logic signed [COORD_WIDTH-1:0]   lo_z_s1,
	input  wire logic signed [COORD_WIDTH-1:0]   hi_x_s1,
	input  wire logic signed [COORD_WIDTH-1:0]   hi_y_s1,
	input  wire logic signed [COORD_WIDTH-1:0]   hi_z_s1,
	input  wire logic [COORD_WIDTH-2:0]          radius_s3,
	output fbsc_pkg::fbsc_flags_t                flags_s4
);
	import fbsc_pkg::*;

	localparam int PROD_W  = COORD_WIDTH + COEF_W;
	localparam int DTERM_W = COEF_W + NORM_FRAC;
	localparam int DIST_W  = ((PROD_W > DTERM_W) ? PROD_W : DTERM_W) + 2;
	localparam int RAD_W   = COORD_WIDTH - 1 + NORM_FRAC;

	logic signed [COEF_W-1:0] nx, ny, nz, d;

	logic signed [PROD_W-1:0] pxl_s2, pxh_s2, pyl_s2, pyh_s2, pzl_s2, pzh_s2;
	logic signed [PROD_W-1:0] xmax, xmin, ymax, ymin, zmax, zmin;
	logic signed [DIST_W-1:0] dterm;
	logic signed [DIST_W-1:0] dmax_s3, dmin_s3;
	logic signed [DIST_W-1:0] r_pos, r_neg;

	// Unpack the plane: normal in Q1.14, offset in Q8.8.
	assign nx = plane[COEF_W-1:0];
	assign ny = plane[2*COEF_W-1:COEF_W];
	assign nz = plane[3*COEF_W-1:2*COEF_W];
	assign d  = plane[4*COEF_W-1:3*COEF_W];

	// Stage 2: both corner products for each axis.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			pxl_s2 <= nx * lo_x_s1;
			pxh_s2 <= nx * hi_x_s1;
			pyl_s2 <= ny * lo_y_s1;
			pyh_s2 <= ny * hi_y_s1;
			pzl_s2 <= nz * lo_z_s1;
			pzh_s2 <= nz * hi_z_s1;
		end
	end

	// The distance is separable per axis, so the nearest and farthest corners
	// come from picking the smaller and larger product on each axis.
	always_comb begin
		xmax  = (pxl_s2 > pxh_s2) ? pxl_s2 : pxh_s2;
		xmin  = (pxl_s2 > pxh_s2) ? pxh_s2 : pxl_s2;
		ymax  = (pyl_s2 > pyh_s2) ? pyl_s2 : pyh_s2;
		ymin  = (pyl_s2 > pyh_s2) ? pyh_s2 : pyl_s2;
		zmax  = (pzl_s2 > pzh_s2) ? pzl_s2 : pzh_s2;
		zmin  = (pzl_s2 > pzh_s2) ? pzh_s2 : pzl_s2;
		dterm = {{(DIST_W-DTERM_W){d[COEF_W-1]}}, d, {NORM_FRAC{1'b0}}};
	end

	// Stage 3: largest and smallest corner distance.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			dmax_s3 <= {{(DIST_W-PROD_W){xmax[PROD_W-1]}}, xmax}
			         + {{(DIST_W-PROD_W){ymax[PROD_W-1]}}, ymax}
			         + {{(DIST_W-PROD_W){zmax[PROD_W-1]}}, zmax} + dterm;
			dmin_s3 <= {{(DIST_W-PROD_W){xmin[PROD_W-1]}}, xmin}
			         + {{(DIST_W-PROD_W){ymin[PROD_W-1]}}, ymin}
			         + {{(DIST_W-PROD_W){zmin[PROD_W-1]}}, zmin} + dterm;
		end
	end

	// Radius in the same units as the distance.
	assign r_pos = {{(DIST_W-RAD_W){1'b0}}, radius_s3, {NORM_FRAC{1'b0}}};
	assign r_neg = -r_pos;

	// Stage 4: sign and radius compares. For a sphere both distances match.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			flags_s4.any_front   <= (dmax_s3 > DIST_W'(0));
			flags_s4.all_front   <= (dmin_s3 > DIST_W'(0));
			flags_s4.below_neg_r <= (dmin_s3 < r_neg);
			flags_s4.below_r     <= (dmin_s3 < r_pos);
		end
	end

endmodule

`default_nettype wire

### design/frustum_box_sphere_cull_core.sv
// Frustum cull core: box or sphere against six configured planes.
// Pipeline: an accepted item moves through stages s1 to s4; its result is valid from s4.
// Throughput: one item per cycle while the output is not stalled; the six plane lanes run in parallel, each stage
// holds one item and a stage fills whenever it is empty or its item moves on.
// Reset: arst_n clears all planes to zero and empties the pipeline.
`default_nettype none

module frustum_box_sphere_cull_core #(
	parameter int COORD_WIDTH = fbsc_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [fbsc_pkg::PLANE_IDX_W-1:0]    cfg_index,
	input  wire logic [fbsc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                operation,
	input  wire logic signed [COORD_WIDTH-1:0]       min_x,
	input  wire logic signed [COORD_WIDTH-1:0]       min_y,
	input  wire logic signed [COORD_WIDTH-1:0]       min_z,
	input  wire logic signed [COORD_WIDTH-1:0]       max_x,
	input  wire logic signed [COORD_WIDTH-1:0]       max_y,
	input  wire logic signed [COORD_WIDTH-1:0]       max_z,
	input  wire logic [COORD_WIDTH-2:0]              sphere_radius,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [1:0]                               verdict
);
	import fbsc_pkg::*;

	logic [NUM_PLANES-1:0][CFG_DATA_W-1:0] planes;

	logic                          valid_s1, valid_s2, valid_s3, valid_s4;
	logic                          ready_s1, ready_s2, ready_s3, ready_s4;
	fbsc_stage_en_t                en;
	logic                          op_s1, op_s2, op_s3, op_s4;
	logic signed [COORD_WIDTH-1:0] lo_x_s1, lo_y_s1, lo_z_s1;
	logic signed [COORD_WIDTH-1:0] hi_x_s1, hi_y_s1, hi_z_s1;
	logic [COORD_WIDTH-2:0]        radius_s1, radius_s2, radius_s3;
	fbsc_flags_t                   flags_s4 [NUM_PLANES];
	logic                          is_sphere;
	fbsc_verdict_t                 verdict_d;

	fbsc_plane_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.planes    (planes)
	);

	// A stage takes a new item when it is empty or its item moves on.
	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign en       = '{s2: ready_s2, s3: ready_s3, s4: ready_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: capture the item. A sphere uses its center as both box corners.
	assign is_sphere = (operation == OP_SPHERE);

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			op_s1     <= operation;
			lo_x_s1   <= min_x;
			lo_y_s1   <= min_y;
			lo_z_s1   <= min_z;
			hi_x_s1   <= is_sphere ? min_x : max_x;
			hi_y_s1   <= is_sphere ? min_y : max_y;
			hi_z_s1   <= is_sphere ? min_z : max_z;
			radius_s1 <= sphere_radius;
		end
	end

	// Operation and radius travel alongside the lanes.
	always_ff @(posedge clk) begin
		if (ready_s2) begin
			op_s2     <= op_s1;
			radius_s2 <= radius_s1;
		end
		if (ready_s3) begin
			op_s3     <= op_s2;
			radius_s3 <= radius_s2;
		end
		if (ready_s4) begin
			op_s4 <= op_s3;
		end
	end

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
		fbsc_plane_lane #(
			.COORD_WIDTH (COORD_WIDTH)
		) u_lane (
			.clk       (clk),
			.en        (en),
			.plane     (planes[p]),
			.lo_x_s1   (lo_x_s1),
			.lo_y_s1   (lo_y_s1),
			.lo_z_s1   (lo_z_s1),
			.hi_x_s1   (hi_x_s1),
			.hi_y_s1   (hi_y_s1),
			.hi_z_s1   (hi_z_s1),
			.radius_s3 (radius_s3),
			.flags_s4  (flags_s4[p])
		);
	end

	// Combine the six plane results into the verdict.
	always_comb begin
		logic any_out, all_in, any_cross;
		any_out   = 1'b0;
		all_in    = 1'b1;
		any_cross = 1'b0;
		for (int p = 0; p < NUM_PLANES; p++) begin
			if (op_s4 == OP_SPHERE) begin
				any_out   = any_out | flags_s4[p].below_neg_r;
				any_cross = any_cross | flags_s4[p].below_r;
			end else begin
				any_out = any_out | !flags_s4[p].any_front;
				all_in  = all_in & flags_s4[p].all_front;
			end
		end
		if (any_out) begin
			verdict_d = VERDICT_OUTSIDE;
		end else if ((op_s4 == OP_SPHERE) ? any_cross : !all_in) begin
			verdict_d = VERDICT_INTERSECT;
		end else begin
			verdict_d = VERDICT_INSIDE;
		end
	end

	assign out_valid = valid_s4;
	assign verdict   = verdict_d;

endmodule

`default_nettype wire

### design/fbsc_checker.sv
// Port-level checker for the frustum cull core, bound to the top level.
// Depends on the assertion macros header.
`include "frustum_box_sphere_cull_core_macros.svh"
`default_nettype none

module fbsc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] verdict
);

	// A result waiting on the output holds its value.
	`FBSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(verdict))

	// The input side only stalls when every stage is full behind a held result.
	`FBSC_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready)

	// With the output draining, an accepted item reaches the output once it has passed through every stage.
	`FBSC_ASSERT_NEXT(a_latency, in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)

endmodule

bind frustum_box_sphere_cull_core fbsc_checker u_fbsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.verdict   (verdict)
);

`default_nettype wire
